@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the source address counter RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CHK_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence on the next clock edge.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/smpc_pkg.sv @@
// Package for the source address packet counter: transaction types,
// command codes, controller states and default sizes. No dependencies.
`default_nettype none

package smpc_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int COUNT_BITS_DEF    = 32;
    localparam int MAC_W             = 48;
    localparam int SLOT_W            = 6;
    localparam int OUT_COUNT_W       = 32;
    localparam int USED_W            = 7;
    localparam int USED_MAX          = 127;

    typedef enum logic [1:0] {
        CMD_COUNT = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RDWAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]        command;
        logic [MAC_W-1:0]  src_mac;
        logic [SLOT_W-1:0] read_slot;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0]      entry_slot;
        logic [MAC_W-1:0]       entry_mac;
        logic [OUT_COUNT_W-1:0] entry_count;
        logic                   entry_valid;
        logic                   new_entry;
        logic                   table_full;
        logic [USED_W-1:0]      entries_used;
    } rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/smpc_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the address and count tables. No dependencies.
`default_nettype none

module smpc_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 48,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/smpc_ctrl.sv @@
// Controller for the source address packet counter: command sequencing,
// table scan, count update, fill level and output register.
// Depends on smpc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module smpc_ctrl #(
    parameter int TABLE_ENTRIES = smpc_pkg::TABLE_ENTRIES_DEF,
    parameter int COUNT_BITS    = smpc_pkg::COUNT_BITS_DEF,
    parameter int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         req_valid,
    output logic                              req_stall,
    input  wire smpc_pkg::req_t               req,
    output logic                              rsp_valid,
    input  wire logic                         rsp_stall,
    output smpc_pkg::rsp_t                    rsp,
    output logic                              mem_rd_en,
    output logic [IDX_W-1:0]                  mem_rd_addr,
    output logic [IDX_W-1:0]                  mem_wr_addr,
    output logic                              addr_wr_en,
    output logic [smpc_pkg::MAC_W-1:0]        addr_wr_data,
    input  wire logic [smpc_pkg::MAC_W-1:0]   addr_rd_data,
    output logic                              cnt_wr_en,
    output logic [COUNT_BITS-1:0]             cnt_wr_data,
    input  wire logic [COUNT_BITS-1:0]        cnt_rd_data
);

    localparam int LVL_W = $clog2(TABLE_ENTRIES + 1);

    smpc_pkg::state_t                state_reg, state_next;
    logic [LVL_W-1:0]                fill_reg, fill_next;
    logic [IDX_W-1:0]                chk_idx_reg, chk_idx_next;
    logic [smpc_pkg::MAC_W-1:0]      mac_reg, mac_next;
    logic [smpc_pkg::SLOT_W-1:0]     slot_reg, slot_next;
    smpc_pkg::rsp_t                  res_reg, res_next;
    smpc_pkg::rsp_t                  out_reg, out_next;
    logic                            out_valid_reg, out_valid_next;

    logic                            accept;
    logic                            out_free;
    logic                            fill_zero;
    logic                            has_room;
    logic                            rd_live;
    logic                            hit;
    logic                            last;
    logic                            do_miss;
    logic [smpc_pkg::MAC_W-1:0]      mac_cur;
    logic [COUNT_BITS-1:0]           cnt_inc;

    function automatic logic [smpc_pkg::USED_W-1:0] used_sat(input logic [LVL_W-1:0] lvl);
        return (32'(lvl) > 32'(smpc_pkg::USED_MAX)) ? smpc_pkg::USED_W'(smpc_pkg::USED_MAX)
                                                     : smpc_pkg::USED_W'(lvl);
    endfunction

    function automatic logic [smpc_pkg::OUT_COUNT_W-1:0] cnt_out(
        input logic [COUNT_BITS-1:0] c
    );
        logic [63:0] w;
        w = 64'(c);
        return (|w[63:32]) ? '1 : w[31:0];
    endfunction

    assign req_stall = (state_reg != smpc_pkg::ST_IDLE);
    assign accept    = req_valid && (state_reg == smpc_pkg::ST_IDLE);
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign fill_zero = (fill_reg == '0);
    assign has_room  = (32'(fill_reg) < 32'(TABLE_ENTRIES));
    assign rd_live   = (32'(req.read_slot) < 32'(fill_reg));
    assign hit       = (addr_rd_data == mac_reg);
    assign last      = ((32'(chk_idx_reg) + 32'd1) == 32'(fill_reg));
    assign mac_cur   = (state_reg == smpc_pkg::ST_IDLE) ? req.src_mac : mac_reg;
    assign cnt_inc   = (cnt_rd_data == '1) ? cnt_rd_data : cnt_rd_data + COUNT_BITS'(1);

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            smpc_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (req.command)
                        smpc_pkg::CMD_COUNT:
                            state_next = fill_zero ? smpc_pkg::ST_EMIT : smpc_pkg::ST_SCAN;
                        smpc_pkg::CMD_READ:
                            state_next = rd_live ? smpc_pkg::ST_RDWAIT : smpc_pkg::ST_EMIT;
                        default:
                            state_next = smpc_pkg::ST_EMIT;
                    endcase
                end
            end
            smpc_pkg::ST_SCAN:
            begin
                if (hit || last)
                begin
                    state_next = smpc_pkg::ST_EMIT;
                end
            end
            smpc_pkg::ST_RDWAIT:
                state_next = smpc_pkg::ST_EMIT;
            smpc_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = smpc_pkg::ST_IDLE;
                end
            end
            default:
                state_next = smpc_pkg::ST_IDLE;
        endcase
    end

    // memory control, table update and result formation
    always_comb
    begin
        fill_next      = fill_reg;
        chk_idx_next   = chk_idx_reg;
        mac_next       = mac_reg;
        slot_next      = slot_reg;
        res_next       = res_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = chk_idx_reg;
        mem_wr_addr    = IDX_W'(fill_reg);
        addr_wr_en     = 1'b0;
        addr_wr_data   = mac_cur;
        cnt_wr_en      = 1'b0;
        cnt_wr_data    = COUNT_BITS'(1);
        do_miss        = 1'b0;

        case (state_reg)
            smpc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    mac_next  = req.src_mac;
                    slot_next = req.read_slot;
                    case (req.command)
                        smpc_pkg::CMD_COUNT:
                        begin
                            if (fill_zero)
                            begin
                                do_miss = 1'b1;
                            end
                            else
                            begin
                                mem_rd_en    = 1'b1;
                                mem_rd_addr  = '0;
                                chk_idx_next = '0;
                            end
                        end
                        smpc_pkg::CMD_READ:
                        begin
                            if (rd_live)
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = IDX_W'(req.read_slot);
                            end
                            else
                            begin
                                res_next              = '0;
                                res_next.entry_slot   = req.read_slot;
                                res_next.entries_used = used_sat(fill_reg);
                            end
                        end
                        smpc_pkg::CMD_CLEAR:
                        begin
                            fill_next = '0;
                            res_next  = '0;
                        end
                        default:
                        begin
                            res_next              = '0;
                            res_next.entries_used = used_sat(fill_reg);
                        end
                    endcase
                end
            end
            smpc_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    cnt_wr_en             = 1'b1;
                    mem_wr_addr           = chk_idx_reg;
                    cnt_wr_data           = cnt_inc;
                    res_next.entry_slot   = smpc_pkg::SLOT_W'(chk_idx_reg);
                    res_next.entry_mac    = mac_reg;
                    res_next.entry_count  = cnt_out(cnt_inc);
                    res_next.entry_valid  = 1'b1;
                    res_next.new_entry    = 1'b0;
                    res_next.table_full   = 1'b0;
                    res_next.entries_used = used_sat(fill_reg);
                end
                else if (last)
                begin
                    do_miss = 1'b1;
                end
                else
                begin
                    mem_rd_en    = 1'b1;
                    mem_rd_addr  = chk_idx_reg + IDX_W'(1);
                    chk_idx_next = chk_idx_reg + IDX_W'(1);
                end
            end
            smpc_pkg::ST_RDWAIT:
            begin
                res_next.entry_slot   = slot_reg;
                res_next.entry_mac    = addr_rd_data;
                res_next.entry_count  = cnt_out(cnt_rd_data);
                res_next.entry_valid  = 1'b1;
                res_next.new_entry    = 1'b0;
                res_next.table_full   = 1'b0;
                res_next.entries_used = used_sat(fill_reg);
            end
            default:
            begin
            end
        endcase

        // append a new address, or flag a full table
        if (do_miss)
        begin
            res_next = '0;
            if (has_room)
            begin
                addr_wr_en            = 1'b1;
                cnt_wr_en             = 1'b1;
                mem_wr_addr           = IDX_W'(fill_reg);
                fill_next             = fill_reg + LVL_W'(1);
                res_next.entry_slot   = smpc_pkg::SLOT_W'(fill_reg);
                res_next.entry_mac    = mac_cur;
                res_next.entry_count  = smpc_pkg::OUT_COUNT_W'(1);
                res_next.entry_valid  = 1'b1;
                res_next.new_entry    = 1'b1;
                res_next.entries_used = used_sat(fill_reg + LVL_W'(1));
            end
            else
            begin
                res_next.table_full   = 1'b1;
                res_next.entries_used = used_sat(fill_reg);
            end
        end
    end

    // output register
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == smpc_pkg::ST_EMIT) && out_free)
        begin
            out_next       = res_reg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= smpc_pkg::ST_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= chk_idx_next;
        mac_reg     <= mac_next;
        slot_reg    <= slot_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    `CHK_PROP(a_fill_bound, 32'(fill_reg) <= 32'(TABLE_ENTRIES), "fill level beyond table size")
    `CHK_PROP(a_rd_live, !mem_rd_en || (32'(mem_rd_addr) < 32'(fill_reg)), "read of a dead slot")
    `CHK_PROP(a_wr_bound, !cnt_wr_en || (32'(mem_wr_addr) <= 32'(fill_reg)), "write past fill level")
    `CHK_NEXT(a_append, addr_wr_en, fill_reg == $past(fill_reg) + LVL_W'(1), "append lost")
    `CHK_PROP(a_out_src, !$rose(out_valid_reg) || ($past(state_reg) == smpc_pkg::ST_EMIT), "result out of order")

endmodule

`default_nettype wire

@@ hw/rtl/source_mac_packet_counter_core.sv @@
// Top level of the source address packet counter: controller plus address
// and count tables. Depends on smpc_pkg, smpc_ram and smpc_ctrl.
//
//   channel   valid      stall      payload   transaction
//   request   req_valid  req_stall  req       count, read or clear command
//   response  rsp_valid  rsp_stall  rsp       one result per command
//
// Count command: the scan reads one slot per cycle from the address table
// up to a hit or the last live slot; an empty table skips the scan. A live
// read passes a read-wait state; clear, dead read, unused code go to emit.
// Reset clears state, fill and output valid; tables never read above fill.
// A stalled response holds the controller in its emit state.
`default_nettype none

module source_mac_packet_counter_core #(
    parameter int TABLE_ENTRIES = smpc_pkg::TABLE_ENTRIES_DEF,
    parameter int COUNT_BITS    = smpc_pkg::COUNT_BITS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire smpc_pkg::req_t  req,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output smpc_pkg::rsp_t       rsp
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic                        mem_rd_en;
    logic [IDX_W-1:0]            mem_rd_addr;
    logic [IDX_W-1:0]            mem_wr_addr;
    logic                        addr_wr_en;
    logic [smpc_pkg::MAC_W-1:0]  addr_wr_data;
    logic [smpc_pkg::MAC_W-1:0]  addr_rd_data;
    logic                        cnt_wr_en;
    logic [COUNT_BITS-1:0]       cnt_wr_data;
    logic [COUNT_BITS-1:0]       cnt_rd_data;

    smpc_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNT_BITS    (COUNT_BITS),
        .IDX_W         (IDX_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req          (req),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .rsp          (rsp),
        .mem_rd_en    (mem_rd_en),
        .mem_rd_addr  (mem_rd_addr),
        .mem_wr_addr  (mem_wr_addr),
        .addr_wr_en   (addr_wr_en),
        .addr_wr_data (addr_wr_data),
        .addr_rd_data (addr_rd_data),
        .cnt_wr_en    (cnt_wr_en),
        .cnt_wr_data  (cnt_wr_data),
        .cnt_rd_data  (cnt_rd_data)
    );

    smpc_ram #(
        .DEPTH  (TABLE_ENTRIES),
        .WIDTH  (smpc_pkg::MAC_W),
        .ADDR_W (IDX_W)
    ) u_addr_ram (
        .clk     (clk),
        .wr_en   (addr_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (addr_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (addr_rd_data)
    );

    smpc_ram #(
        .DEPTH  (TABLE_ENTRIES),
        .WIDTH  (COUNT_BITS),
        .ADDR_W (IDX_W)
    ) u_cnt_ram (
        .clk     (clk),
        .wr_en   (cnt_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (cnt_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (cnt_rd_data)
    );

endmodule

`default_nettype wire
